/* src/whs_pkg.sv */
// ----------------------------------------------------------------------------
// whs_pkg
// Shared types, constants and helpers for the wave height field step unit.
// ----------------------------------------------------------------------------
package whs_pkg;

  localparam int unsigned DATA_W     = 24;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned CELL_W     = 2 * COORD_W;
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned MUL_A_W    = 28;
  localparam int unsigned MUL_B_W    = 20;
  localparam int unsigned MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam logic [COORD_W-1:0] COORD_LAST = '1;
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [3:0]  MAX_SUBSTEPS = 4'd8;

  typedef enum logic [2:0] {
    CFG_COLS   = 3'd0,
    CFG_ROWS   = 3'd1,
    CFG_GAIN   = 3'd2,
    CFG_STIME  = 3'd3,
    CFG_DAMP   = 3'd4,
    CFG_SUBST  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_DROP = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  // clip to signed 24 bit range
  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [32:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 33'sd8388607) begin
      r = 24'sh7fffff;
    end else if (x < -33'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/whs_mul.sv */
// ----------------------------------------------------------------------------
// whs_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module whs_mul (
  input  logic                                  clk_i,
  input  logic signed [whs_pkg::MUL_A_W-1:0]    a_i,
  input  logic signed [whs_pkg::MUL_B_W-1:0]    b_i,
  output logic signed [whs_pkg::MUL_P_W-1:0]    p_o
);

  logic signed [whs_pkg::MUL_P_W-1:0] p_q;
  logic signed [whs_pkg::MUL_P_W-1:0] p_d;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

/* src/wave_heightfield_step_unit.sv */
// ----------------------------------------------------------------------------
// wave_heightfield_step_unit
// Damped wave height field on a 64 x 64 grid with drop, tick and read words.
// ----------------------------------------------------------------------------
// One word is worked at a time; the block stalls its input until the result
// word is built. After reset a clearing pass over all 4096 cells zeroes the
// live height bank and the velocity memory before the first word is taken.
// A read fetches one height. A drop visits the (2r+1)^2 offsets: full weight
// at the centre, none outside the circle, a bit-serial weight search inside.
// A tick sweeps all 4096 cells per substep; in-use cells read their four
// neighbours and use three multiplies, other cells are only copied. The one
// shared multiplier and the height memory's single read port set the pace.
module wave_heightfield_step_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [whs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [5:0]                    col_i,
  input  logic [5:0]                    row_i,
  input  logic signed [23:0]            strength_i,
  input  logic [2:0]                    radius_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [23:0]            height_o,
  output logic [1:0]                    kind_o
);

  typedef enum logic [22:0] {
    ST_CLR    = 23'd1 << 0,
    ST_IDLE   = 23'd1 << 1,
    ST_RD0    = 23'd1 << 2,
    ST_RD1    = 23'd1 << 3,
    ST_SU_R0  = 23'd1 << 4,
    ST_SU_R1  = 23'd1 << 5,
    ST_SU_R2  = 23'd1 << 6,
    ST_SU_R3  = 23'd1 << 7,
    ST_SU_R4  = 23'd1 << 8,
    ST_SU_LAP = 23'd1 << 9,
    ST_SU_M1  = 23'd1 << 10,
    ST_SU_A1  = 23'd1 << 11,
    ST_SU_M2  = 23'd1 << 12,
    ST_SU_A2  = 23'd1 << 13,
    ST_SU_M3  = 23'd1 << 14,
    ST_SU_W   = 23'd1 << 15,
    ST_D_RD   = 23'd1 << 16,
    ST_D_S1   = 23'd1 << 17,
    ST_D_S2   = 23'd1 << 18,
    ST_D_S3   = 23'd1 << 19,
    ST_D_M    = 23'd1 << 20,
    ST_D_A    = 23'd1 << 21,
    ST_FIN    = 23'd1 << 22
  } state_e;

  state_e st_q;

  // configuration
  logic [5:0]  cols_q, rows_q;
  logic [15:0] gain_q, stime_q;
  logic [16:0] damp_q;
  logic [3:0]  nsub_q;
  logic [16:0] damp_eff;
  logic [3:0]  nsub_eff;

  // item
  logic [1:0]         func_q;
  logic [5:0]         col_q, row_q;
  logic signed [23:0] str_q;
  logic [2:0]         rad_q;
  logic signed [23:0] res_q;

  // sweep
  logic       bank_q;
  logic [11:0] clr_q;
  logic [5:0] x_q, z_q;
  logic [3:0] sub_q;
  logic       in_area, last_cell, last_sub;
  logic [5:0] xl, xr, zu, zd;

  // datapath
  logic signed [23:0] h_q, v_q;
  logic signed [26:0] acc_q;
  logic signed [26:0] lap_d;

  // drop
  logic signed [3:0]  dx_q, dz_q;
  logic signed [3:0]  rs;
  logic [2:0]         adx, adz;
  logic [6:0]         d2_c, r2_c, d2_q;
  logic signed [7:0]  sx, sz;
  logic [5:0]         ix, iz;
  logic [11:0]        vidx_q;
  logic [15:0]        tp_q, cand, tp_new;
  logic [3:0]         bit_q;
  logic [16:0]        w_q;
  logic               lt;
  logic               last_off;

  // memories
  logic signed [23:0] hmem [2**(whs_pkg::CELL_W+1)];
  logic signed [23:0] vmem [2**whs_pkg::CELL_W];
  logic [whs_pkg::CELL_W:0]   h_ra, h_wa;
  logic [whs_pkg::CELL_W-1:0] v_ra, v_wa;
  logic                       h_we, v_we, v_re;
  logic signed [23:0]         h_wd, v_wd, h_rd_q, v_rd_q;

  // multiplier
  logic signed [whs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [whs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [whs_pkg::MUL_P_W-1:0] p_q;
  logic signed [31:0]                 prod_hi;

  // output
  logic               out_valid_q;
  logic signed [23:0] height_q;
  logic [1:0]         kind_q;

  logic in_acc;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign height_o    = height_q;
  assign kind_o      = kind_q;

  assign damp_eff = (damp_q > whs_pkg::ONE_Q16) ? whs_pkg::ONE_Q16 : damp_q;
  assign nsub_eff = (nsub_q == 4'd0) ? 4'd1 :
                    (nsub_q > whs_pkg::MAX_SUBSTEPS) ? whs_pkg::MAX_SUBSTEPS : nsub_q;

  assign prod_hi = p_q[47:16];

  // substep neighbours, clamped to the in-use area
  assign in_area   = (x_q <= cols_q) && (z_q <= rows_q);
  assign last_cell = (x_q == whs_pkg::COORD_LAST) && (z_q == whs_pkg::COORD_LAST);
  assign last_sub  = (4'(sub_q + 4'd1) >= nsub_eff);
  assign xl = (x_q == 6'd0) ? 6'd0 : 6'(x_q - 6'd1);
  assign xr = (x_q >= cols_q) ? cols_q : 6'(x_q + 6'd1);
  assign zu = (z_q == 6'd0) ? 6'd0 : 6'(z_q - 6'd1);
  assign zd = (z_q >= rows_q) ? rows_q : 6'(z_q + 6'd1);

  assign lap_d = acc_q + 27'(h_rd_q) - (27'(h_q) <<< 2);

  // drop offsets
  assign rs   = $signed({1'b0, rad_q});
  assign adx  = dx_q[3] ? 3'(-dx_q) : dx_q[2:0];
  assign adz  = dz_q[3] ? 3'(-dz_q) : dz_q[2:0];
  assign d2_c = 7'(7'(adx) * 7'(adx)) + 7'(7'(adz) * 7'(adz));
  assign r2_c = 7'(7'(rad_q) * 7'(rad_q));
  assign sx   = $signed({2'b00, col_q}) + 8'(dx_q);
  assign sz   = $signed({2'b00, row_q}) + 8'(dz_q);
  assign ix   = (sx < 8'sd0) ? 6'd0 :
                (sx > $signed({2'b00, cols_q})) ? cols_q : sx[5:0];
  assign iz   = (sz < 8'sd0) ? 6'd0 :
                (sz > $signed({2'b00, rows_q})) ? rows_q : sz[5:0];
  assign last_off = (dx_q == rs) && (dz_q == rs);

  // weight search: largest t with (t*r)^2 below d2 << 32
  assign cand   = tp_q | (16'd1 << bit_q);
  assign lt     = $unsigned(p_q) < {9'd0, d2_q, 32'd0};
  assign tp_new = lt ? cand : tp_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      ST_SU_M1: begin
        mul_a = 28'(acc_q);
        mul_b = $signed({4'd0, gain_q});
      end
      ST_SU_M2: begin
        mul_a = 28'(v_q);
        mul_b = $signed({3'd0, damp_eff});
      end
      ST_SU_M3: begin
        mul_a = 28'(v_q);
        mul_b = $signed({4'd0, stime_q});
      end
      ST_D_S1: begin
        mul_a = $signed({12'd0, cand});
        mul_b = $signed({17'd0, rad_q});
      end
      ST_D_S2: begin
        mul_a = $signed({9'd0, p_q[18:0]});
        mul_b = $signed({1'b0, p_q[18:0]});
      end
      ST_D_M: begin
        mul_a = 28'(str_q);
        mul_b = $signed({3'd0, w_q});
      end
      default: begin
      end
    endcase
  end

  whs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  // memory port control
  always_comb begin
    h_ra = {bank_q, z_q, x_q};
    v_ra = {z_q, x_q};
    v_re = 1'b0;
    h_we = 1'b0;
    h_wa = {~bank_q, z_q, x_q};
    h_wd = h_rd_q;
    v_we = 1'b0;
    v_wa = {z_q, x_q};
    v_wd = v_q;
    case (st_q)
      ST_CLR: begin
        h_we = 1'b1;
        h_wa = {1'b0, clr_q};
        h_wd = '0;
        v_we = 1'b1;
        v_wa = clr_q;
        v_wd = '0;
      end
      ST_RD0:   h_ra = {bank_q, row_q, col_q};
      ST_SU_R0: v_re = 1'b1;
      ST_SU_R1: begin
        h_ra = {bank_q, z_q, xl};
        h_we = !in_area;
      end
      ST_SU_R2: h_ra = {bank_q, z_q, xr};
      ST_SU_R3: h_ra = {bank_q, zu, x_q};
      ST_SU_R4: h_ra = {bank_q, zd, x_q};
      ST_SU_W: begin
        h_we = 1'b1;
        h_wd = whs_pkg::sat24(33'(h_q) + 33'(prod_hi));
        v_we = 1'b1;
      end
      ST_D_RD: begin
        v_ra = {iz, ix};
        v_re = 1'b1;
      end
      ST_D_A: begin
        v_we = 1'b1;
        v_wa = vidx_q;
        v_wd = whs_pkg::sat24(33'(v_rd_q) + 33'(prod_hi));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_rd_q <= hmem[h_ra];
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_re) begin
      v_rd_q <= vmem[v_ra];
    end
    if (v_we) begin
      vmem[v_wa] <= v_wd;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= 6'd63;
      rows_q  <= 6'd63;
      gain_q  <= 16'd655;
      stime_q <= 16'd1049;
      damp_q  <= 17'd65536;
      nsub_q  <= 4'd1;
    end else if (cfg_we_i) begin
      case (whs_pkg::cfg_idx_e'(cfg_idx_i))
        whs_pkg::CFG_COLS:  cols_q  <= cfg_data_i[5:0];
        whs_pkg::CFG_ROWS:  rows_q  <= cfg_data_i[5:0];
        whs_pkg::CFG_GAIN:  gain_q  <= cfg_data_i[15:0];
        whs_pkg::CFG_STIME: stime_q <= cfg_data_i[15:0];
        whs_pkg::CFG_DAMP:  damp_q  <= cfg_data_i;
        whs_pkg::CFG_SUBST: nsub_q  <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLR;
      clr_q       <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      z_q         <= '0;
      sub_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (st_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_CLR: begin
          clr_q <= 12'(clr_q + 12'd1);
          if (clr_q == '1) begin
            st_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            func_q <= func_i;
            col_q  <= (col_i > cols_q) ? cols_q : col_i;
            row_q  <= (row_i > rows_q) ? rows_q : row_i;
            str_q  <= strength_i;
            rad_q  <= (radius_i == 3'd0) ? 3'd1 : radius_i;
            dx_q   <= -$signed({1'b0, ((radius_i == 3'd0) ? 3'd1 : radius_i)});
            dz_q   <= -$signed({1'b0, ((radius_i == 3'd0) ? 3'd1 : radius_i)});
            res_q  <= '0;
            x_q    <= '0;
            z_q    <= '0;
            sub_q  <= '0;
            case (whs_pkg::func_e'(func_i))
              whs_pkg::FUNC_TICK: st_q <= ST_SU_R0;
              whs_pkg::FUNC_DROP: st_q <= ST_D_RD;
              whs_pkg::FUNC_READ: st_q <= ST_RD0;
              default:            st_q <= ST_FIN;
            endcase
          end
        end
        ST_RD0: st_q <= ST_RD1;
        ST_RD1: begin
          res_q <= h_rd_q;
          st_q  <= ST_FIN;
        end
        ST_SU_R0: st_q <= ST_SU_R1;
        ST_SU_R1: begin
          h_q <= h_rd_q;
          v_q <= v_rd_q;
          if (in_area) begin
            st_q <= ST_SU_R2;
          end else begin
            st_q <= ST_SU_W;
          end
        end
        ST_SU_R2: begin
          acc_q <= 27'(h_rd_q);
          st_q  <= ST_SU_R3;
        end
        ST_SU_R3: begin
          acc_q <= acc_q + 27'(h_rd_q);
          st_q  <= ST_SU_R4;
        end
        ST_SU_R4: begin
          acc_q <= acc_q + 27'(h_rd_q);
          st_q  <= ST_SU_LAP;
        end
        ST_SU_LAP: begin
          acc_q <= lap_d;
          st_q  <= ST_SU_M1;
        end
        ST_SU_M1: st_q <= ST_SU_A1;
        ST_SU_A1: begin
          v_q  <= whs_pkg::sat24(33'(v_q) + 33'(prod_hi));
          st_q <= ST_SU_M2;
        end
        ST_SU_M2: st_q <= ST_SU_A2;
        ST_SU_A2: begin
          v_q  <= whs_pkg::sat24(33'(prod_hi));
          st_q <= ST_SU_M3;
        end
        ST_SU_M3: st_q <= ST_SU_W;
        ST_SU_W: begin
          // cells outside the area arrive here only as height copies
          x_q <= 6'(x_q + 6'd1);
          if (x_q == whs_pkg::COORD_LAST) begin
            z_q <= 6'(z_q + 6'd1);
          end
          if (last_cell && last_sub) begin
            st_q <= ST_FIN;
          end else begin
            st_q <= ST_SU_R0;
          end
          if (last_cell) begin
            bank_q <= ~bank_q;
            sub_q  <= 4'(sub_q + 4'd1);
          end
        end
        ST_D_RD: begin
          vidx_q <= {iz, ix};
          d2_q   <= d2_c;
          tp_q   <= '0;
          bit_q  <= 4'd15;
          if (d2_c == 7'd0) begin
            w_q  <= whs_pkg::ONE_Q16;
            st_q <= ST_D_M;
          end else if (d2_c >= r2_c) begin
            // zero weight leaves the cell unchanged
            if (last_off) begin
              st_q <= ST_FIN;
            end else if (dx_q == rs) begin
              dx_q <= -rs;
              dz_q <= 4'(dz_q + 4'sd1);
            end else begin
              dx_q <= 4'(dx_q + 4'sd1);
            end
          end else begin
            st_q <= ST_D_S1;
          end
        end
        ST_D_S1: st_q <= ST_D_S2;
        ST_D_S2: st_q <= ST_D_S3;
        ST_D_S3: begin
          tp_q <= tp_new;
          if (bit_q == 4'd0) begin
            w_q  <= 17'(whs_pkg::ONE_Q16 - 17'(tp_new) - 17'd1);
            st_q <= ST_D_M;
          end else begin
            bit_q <= 4'(bit_q - 4'd1);
            st_q  <= ST_D_S1;
          end
        end
        ST_D_M: st_q <= ST_D_A;
        ST_D_A: begin
          if (last_off) begin
            st_q <= ST_FIN;
          end else begin
            st_q <= ST_D_RD;
            if (dx_q == rs) begin
              dx_q <= -rs;
              dz_q <= 4'(dz_q + 4'sd1);
            end else begin
              dx_q <= 4'(dx_q + 4'sd1);
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            height_q    <= res_q;
            kind_q      <= func_q;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  a_no_out_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLR) |-> !out_valid_q)
    else $error("result word during clearing pass");

  a_bank_flip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> ($past(st_q) == ST_SU_W))
    else $error("bank flipped outside a sweep end");

  a_offset_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_D_RD) |-> (dx_q >= -rs) && (dx_q <= rs) && (dz_q >= -rs) && (dz_q <= rs))
    else $error("drop offset outside radius");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q != ST_IDLE))
    else $error("accepted word did not start work");

endmodule

/* tb/sv/wave_heightfield_checker.sv */
// ----------------------------------------------------------------------------
// wave_heightfield_checker
// Watches the register port and both word channels of the height field unit,
// keeps its own copy of the grid and compares every result word in order.
// ----------------------------------------------------------------------------
module wave_heightfield_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [whs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    func_i,
  input  logic [5:0]                    col_i,
  input  logic [5:0]                    row_i,
  input  logic signed [23:0]            strength_i,
  input  logic [2:0]                    radius_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic signed [23:0]            height_i,
  input  logic [1:0]                    kind_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE   = 64;
  localparam int NCELLS = SIDE * SIDE;

  typedef struct {
    logic signed [23:0] height;
    logic [1:0]         kind;
  } word_t;

  word_t heights_due[$];

  int heights[2][NCELLS];
  int velocity[NCELLS];
  int bank;

  logic [5:0]  cols_q, rows_q;
  logic [15:0] gain_q, stime_q;
  logic [16:0] damp_q;
  logic [3:0]  subs_q;

  function automatic int clip24(longint x);
    if (x > 64'sd8388607) return 8388607;
    if (x < -64'sd8388608) return -8388608;
    return int'(x);
  endfunction

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // smallest s with s*s >= x
  function automatic longint unsigned root_up(longint unsigned x);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 24;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (mid * mid >= x) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  // floor(65536 * max(0, 1 - sqrt(d2)/r)), exact
  function automatic longint splash_weight(int d2, int r);
    longint unsigned s, t;
    s = root_up(longint'(d2) << 32);
    t = (s + r - 1) / r;
    if (t >= 65536) return 0;
    return 65536 - longint'(t);
  endfunction

  function automatic void splash(int cx, int cz, longint s, int rad);
    int r, ix, iz, i;
    r = (rad == 0) ? 1 : rad;
    for (int z = -r; z <= r; z++) begin
      for (int x = -r; x <= r; x++) begin
        ix = clamp_to(cx + x, cols_q);
        iz = clamp_to(cz + z, rows_q);
        i = iz * SIDE + ix;
        velocity[i] = clip24(velocity[i] + ((s * splash_weight(x * x + z * z, r)) >>> 16));
      end
    end
  endfunction

  function automatic void relax_once();
    int nb, i;
    longint h, lap, v, damp;
    nb = bank ^ 1;
    damp = (damp_q > 17'd65536) ? 65536 : damp_q;
    for (int k = 0; k < NCELLS; k++) heights[nb][k] = heights[bank][k];
    for (int z = 0; z <= rows_q; z++) begin
      for (int x = 0; x <= cols_q; x++) begin
        i = z * SIDE + x;
        h = heights[bank][i];
        lap = longint'(heights[bank][z * SIDE + clamp_to(x - 1, cols_q)])
            + heights[bank][z * SIDE + clamp_to(x + 1, cols_q)]
            + heights[bank][clamp_to(z - 1, rows_q) * SIDE + x]
            + heights[bank][clamp_to(z + 1, rows_q) * SIDE + x]
            - 4 * h;
        v = velocity[i];
        v = clip24(v + ((longint'(gain_q) * lap) >>> 16));
        v = clip24((v * damp) >>> 16);
        velocity[i] = int'(v);
        heights[nb][i] = clip24(h + ((v * longint'(stime_q)) >>> 16));
      end
    end
    bank = nb;
  endfunction

  function automatic word_t predict_word(logic [1:0] f, int c, int r, longint s, int rad);
    word_t w;
    int n;
    w.kind = f;
    w.height = '0;
    c = clamp_to(c, cols_q);
    r = clamp_to(r, rows_q);
    case (whs_pkg::func_e'(f))
      whs_pkg::FUNC_TICK: begin
        n = (subs_q == 0) ? 1 :
            ((subs_q > whs_pkg::MAX_SUBSTEPS) ? int'(whs_pkg::MAX_SUBSTEPS) : int'(subs_q));
        for (int k = 0; k < n; k++) relax_once();
      end
      whs_pkg::FUNC_DROP: splash(c, r, s, rad);
      whs_pkg::FUNC_READ: w.height = 24'(heights[bank][r * SIDE + c]);
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      foreach (heights[b, k]) heights[b][k] = 0;
      foreach (velocity[k]) velocity[k] = 0;
      bank = 0;
      cols_q = 6'd63;
      rows_q = 6'd63;
      gain_q = 16'd655;
      stime_q = 16'd1049;
      damp_q = 17'd65536;
      subs_q = 4'd1;
      heights_due.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (whs_pkg::cfg_idx_e'(cfg_idx_i))
          whs_pkg::CFG_COLS:  cols_q = cfg_data_i[5:0];
          whs_pkg::CFG_ROWS:  rows_q = cfg_data_i[5:0];
          whs_pkg::CFG_GAIN:  gain_q = cfg_data_i[15:0];
          whs_pkg::CFG_STIME: stime_q = cfg_data_i[15:0];
          whs_pkg::CFG_DAMP:  damp_q = cfg_data_i;
          whs_pkg::CFG_SUBST: subs_q = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (heights_due.size() == 0) begin
          $error("unexpected result word: height %0d kind %0d", height_i, kind_i);
          errs++;
        end else begin
          want = heights_due.pop_front();
          if (height_i !== want.height) begin
            $error("height mismatch: expected %0d, actual %0d", want.height, height_i);
            errs++;
          end
          if (kind_i !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, kind_i);
            errs++;
          end
        end
      end
      // predicted after the pop so a same-edge result never meets its own word
      if (in_valid_i && !in_stall_i)
        heights_due.insert(heights_due.size(),
                           predict_word(func_i, col_i, row_i, strength_i, radius_i));
      fail_count_o <= fail_count_o + errs;
    end
    pending_o <= heights_due.size();
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives drop, tick and read words into the wave height field unit under a
// series of grid and damping settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 20_000_000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [2:0]                cfg_idx_i = '0;
  logic [whs_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                func_i = '0;
  logic [5:0]                col_i = '0;
  logic [5:0]                row_i = '0;
  logic signed [23:0]        strength_i = '0;
  logic [2:0]                radius_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [23:0]        height_o;
  logic [1:0]                kind_o;

  int     pending;
  int     fail_count;
  bit     gaps_on = 1'b1;
  longint cycles = 0;

  wave_heightfield_step_unit dut (.*);

  wave_heightfield_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .col_i, .row_i,
    .strength_i, .radius_i, .out_valid_i(out_valid_o), .out_stall_i,
    .height_i(height_o), .kind_i(kind_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_stall_i <= gaps_on && ($urandom_range(99) < 25);
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays up after acceptance so back-to-back words need one assignment
  task automatic push_word(whs_pkg::func_e f, int c, int r, int s, int rad);
    while (gaps_on && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    col_i <= 6'(c);
    row_i <= 6'(r);
    strength_i <= 24'(s);
    radius_i <= 3'(rad);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_regs(int cols, int rows, int gain, int stime, int damp, int subs);
    int vals[6];
    vals = '{cols, rows, gain, stime, damp, subs};
    settle();
    for (int k = 0; k < 6; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= whs_pkg::cfg_idx_e'(k);
      cfg_data_i <= 17'(vals[k]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_word();
    int pick, s;
    whs_pkg::func_e f;
    pick = $urandom_range(99);
    if (pick < 40) f = whs_pkg::FUNC_READ;
    else if (pick < 80) f = whs_pkg::FUNC_DROP;
    else if (pick < 92) f = whs_pkg::FUNC_TICK;
    else f = whs_pkg::FUNC_NONE;
    s = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 1 << 18) - (1 << 17);
    push_word(f, $urandom_range(63), $urandom_range(63), s, $urandom_range(7));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, full grid
    push_word(whs_pkg::FUNC_READ, 0, 0, 0, 0);
    push_word(whs_pkg::FUNC_DROP, 32, 32, 24'sh7fffff, 0);
    push_word(whs_pkg::FUNC_DROP, 0, 0, -24'sh800000, 7);
    push_word(whs_pkg::FUNC_DROP, 63, 63, 24'sh123456, 3);
    push_word(whs_pkg::FUNC_NONE, 63, 63, -1, 7);
    push_word(whs_pkg::FUNC_TICK, 0, 0, 0, 0);
    push_word(whs_pkg::FUNC_READ, 32, 32, 0, 0);
    push_word(whs_pkg::FUNC_READ, 63, 63, 0, 0);

    // one-cell grid, gains at top, damping past one, zero substeps
    load_regs(0, 0, 16'hffff, 16'hffff, 17'h1ffff, 0);
    push_word(whs_pkg::FUNC_DROP, 5, 5, 24'sh7fffff, 7);
    push_word(whs_pkg::FUNC_TICK, 0, 0, 0, 0);
    push_word(whs_pkg::FUNC_READ, 63, 63, 0, 0);
    push_word(whs_pkg::FUNC_TICK, 0, 0, 0, 0);
    push_word(whs_pkg::FUNC_READ, 0, 0, 0, 0);

    // wide strip, zero gains, substeps past the limit
    load_regs(63, 1, 0, 0, 0, 15);
    push_word(whs_pkg::FUNC_DROP, 40, 0, -24'sh400000, 5);
    push_word(whs_pkg::FUNC_TICK, 0, 0, 0, 0);
    push_word(whs_pkg::FUNC_READ, 40, 1, 0, 0);
    push_word(whs_pkg::FUNC_READ, 63, 0, 0, 0);

    for (int ph = 0; ph < 5; ph++) begin
      load_regs($urandom_range(9) == 0 ? 0 : $urandom_range(1, 7),
                $urandom_range(9) == 0 ? 0 : $urandom_range(1, 7),
                $urandom_range(65535), $urandom_range(65535),
                $urandom_range(ph == 2 ? 131071 : 65536),
                ph == 4 ? $urandom_range(15) : $urandom_range(0, 3));
      gaps_on = (ph != 3);
      for (int n = 0; n < 25; n++) random_word();
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
